>>> rtl/rbe_pkg.sv
// Package: shared types, constants and helpers for the rANS byte encoder
package rbe_pkg;
    localparam int unsigned CONTEXTS_DEF  = 256;
    localparam int unsigned FLOOR_LOG_DEF = 23;
    localparam int unsigned OP_W   = 2;
    localparam int unsigned CUM_W  = 16;
    localparam int unsigned FREQ_W = 17;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned ST_W   = 31;
    localparam int unsigned LR_W   = 5;
    localparam logic [LR_W-1:0] LR_RESET = 5'd12;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_STATE = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [7:0]        context_req;
        logic [7:0]        symbol;
        logic [CUM_W-1:0]  cum_freq;
        logic [FREQ_W-1:0] freq;
    } t_in_item;

    typedef struct packed {
        logic              kind;
        logic [DATA_W-1:0] data;
        logic              last;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch item, start table access
        logic write;     // unused; the table entry is written with load
        logic prep;      // latch entry, compute limit and shift
        logic renorm;    // shift state right by a byte
        logic mul1;      // st * inv product register
        logic update;    // write new coder state
        logic flush;     // reload floor value
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic             above;
        logic [OP_W-1:0]  operation;
    } t_status;

    function automatic logic [4:0] sat_lr(input logic [LR_W-1:0] v);
        if (v < 5'd8) return 5'd8;
        if (v > 5'd16) return 5'd16;
        return v;
    endfunction
endpackage

>>> rtl/rbe_if.sv
// Interface: valid/ready channel carrying one payload
interface rbe_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/rbe_recip.sv
// Reciprocal unit: one step per cycle restoring division of 2^(s+31) by f, rounded up
module rbe_recip import rbe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [16:0] i_freq,
    input  logic [4:0]  i_shift,
    output logic        o_done,
    output logic [31:0] o_inv
);
    logic [5:0]  r_cnt, n_cnt;
    logic [17:0] r_rem, n_rem;
    logic [47:0] r_quo, n_quo;
    logic [16:0] r_div;
    logic        r_busy, n_busy;
    logic [18:0] trial;
    logic        bit_in;

    // dividend = 2^(s+31) + f - 1, computed bit-serially from bit 47 down
    logic [47:0] r_num, n_num;

    always_comb begin
        n_cnt = r_cnt; n_rem = r_rem; n_quo = r_quo; n_busy = r_busy; n_num = r_num;
        bit_in = r_num[47];
        trial = {r_rem, bit_in} - {2'b0, r_div};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd48;
            n_rem  = '0;
            n_quo  = '0;
            n_num  = (48'd1 << (6'(i_shift) + 6'd31)) + 48'(i_freq) - 48'd1;
        end else if (r_busy) begin
            n_num = {r_num[46:0], 1'b0};
            if (!trial[18]) begin
                n_rem = trial[17:0];
                n_quo = {r_quo[46:0], 1'b1};
            end else begin
                n_rem = {r_rem[16:0], bit_in};
                n_quo = {r_quo[46:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_num <= n_num;
        if (i_start) r_div <= i_freq;
    end

    // done stays high once finished, quotient held until the next start
    assign o_done = !r_busy || (r_cnt == 6'd1);
    assign o_inv  = n_quo[31:0];
endmodule

>>> rtl/rbe_datapath.sv
// Datapath: symbol table, coder state, renormalisation and update arithmetic
module rbe_datapath import rbe_pkg::*; #(
    parameter int unsigned CONTEXTS  = CONTEXTS_DEF,
    parameter int unsigned FLOOR_LOG = FLOOR_LOG_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_cmd,
    input  t_in_item        i_item,
    input  logic [LR_W-1:0] i_log_range,
    input  logic            i_recip_go,
    output logic            o_recip_done,
    output t_status         o_status,
    output logic [31:0]     o_state32,
    output logic [7:0]      o_byte
);
    localparam int unsigned ROW_W = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
    localparam int unsigned ADDR_W = ROW_W + 8;
    localparam int unsigned DEPTH = CONTEXTS * 256;
    localparam int unsigned ROW_MUL = (1 << 16) / CONTEXTS + 1;

    logic [32:0]       r_mem [DEPTH];
    logic [32:0]       r_rd;
    t_in_item          r_item;
    logic [ST_W-1:0]   r_st;
    logic [ADDR_W-1:0] addr;
    logic [4:0]        lr;
    logic [16:0]       range_v;
    logic [16:0]       fclamp;
    logic [16:0]       r_f;
    logic [15:0]       r_cum;
    logic [39:0]       r_limit;
    logic [4:0]        r_s;
    logic [4:0]        s_v;
    logic [31:0]       r_inv;
    logic [63:0]       r_prod;
    logic [31:0]       q;
    logic              r_fsmall;
    logic [16:0]       fin;
    logic [16:0]       fst;
    logic [7:0]        row;
    logic [23:0]       row_prod;
    logic [7:0]        row_q;
    logic [31:0]       inv_w;
    logic [48:0]       newst;

    assign lr       = sat_lr(i_log_range);
    assign range_v  = 17'(18'd1 << lr);
    // context row by reciprocal multiplication, exact for 8-bit contexts
    assign row_prod = 24'(i_item.context_req) * 24'(ROW_MUL);
    assign row_q    = row_prod[23:16];
    assign row      = 8'(16'(i_item.context_req) - 16'(row_q) * 16'(CONTEXTS));
    assign addr     = {row[ROW_W-1:0], i_item.symbol};
    assign fin      = (i_item.freq >= range_v) ? range_v - 17'd1 : i_item.freq;
    assign fst      = (r_rd[16:0] == 17'd0) ? 17'd1 : r_rd[16:0];
    assign fclamp   = (fst >= range_v) ? range_v - 17'd1 : fst;

    always_comb begin
        s_v = 5'd0;
        for (int k = 16; k >= 0; k--) begin
            if (fclamp <= 17'(18'd1 << k)) s_v = 5'(k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_item;
        if (i_cmd.load && i_item.operation == OP_LOAD) r_mem[addr] <= {i_item.cum_freq, fin};
        if (i_cmd.load) r_rd <= r_mem[addr];
        if (i_cmd.prep) begin
            r_f      <= fclamp;
            r_cum    <= r_rd[32:17];
            r_s      <= s_v;
            r_fsmall <= (fclamp < 17'd2);
            r_limit  <= 40'(fclamp) << (6'(FLOOR_LOG + 8) - 6'(lr));
        end
        if (o_recip_done) r_inv <= inv_w;
        if (i_cmd.mul1)
            r_prod <= 64'(r_st) * (r_fsmall ? 64'hFFFF_FFFF : 64'(r_inv));
    end

    rbe_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_recip_go),
        .i_freq  (fclamp),
        .i_shift (s_v),
        .o_done  (o_recip_done),
        .o_inv   (inv_w)
    );

    assign q = r_fsmall ? r_prod[63:32] : 32'(r_prod >> (6'd31 + 6'(r_s)));

    assign newst = 49'(r_st) + 49'(r_cum)
                 + (r_fsmall ? 49'(range_v) - 49'd1 : 49'd0)
                 + 49'(q) * 49'(range_v - r_f);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_W'(1) << FLOOR_LOG;
        end else if (i_cmd.flush) begin
            r_st <= ST_W'(1) << FLOOR_LOG;
        end else if (i_cmd.renorm) begin
            r_st <= r_st >> 8;
        end else if (i_cmd.update) begin
            r_st <= newst[ST_W-1:0];
        end
    end

    assign o_status.above     = (40'(r_st) >= r_limit);
    assign o_status.operation = r_item.operation;
    assign o_state32 = {1'b0, r_st};
    assign o_byte    = r_st[7:0];
endmodule

>>> rtl/rbe_ctrl.sv
// Controller: sequences table access, renormalisation, update and output
module rbe_ctrl import rbe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_status     i_status,
    input  logic        i_recip_done,
    output logic        o_recip_go,
    output t_cmd        o_cmd,
    input  logic [31:0] i_state32,
    input  logic [7:0]  i_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_RENO  = 3'd3;
    localparam logic [2:0] S_RECIP = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_UPD   = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [1:0]  r_n, n_n;
    logic        r_ov, n_ov;
    t_out_item   r_out, n_out;
    logic        r_hold, n_hold;
    t_out_item   r_hb, n_hb;
    logic        space;

    assign space = !r_ov || i_out_ready;

    always_comb begin
        n_state = r_state; n_n = r_n; n_ov = r_ov; n_out = r_out;
        n_hold = r_hold; n_hb = r_hb;
        o_cmd = '0; o_recip_go = 1'b0; o_in_ready = 1'b0;
        if (r_ov && i_out_ready) n_ov = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                case (i_status.operation)
                    OP_ENCODE: begin
                        o_cmd.prep = 1'b1;
                        o_recip_go = 1'b1;
                        n_n = 2'd0;
                        n_hold = 1'b0;
                        n_state = S_RENO;
                    end
                    OP_FLUSH: begin
                        if (space) begin
                            n_ov = 1'b1;
                            n_out = '{kind: KIND_STATE, data: i_state32, last: 1'b1};
                            o_cmd.flush = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_RENO: begin
                if (r_n != 2'd2 && i_status.above) begin
                    if (!r_hold || space) begin
                        if (r_hold) begin
                            n_ov = 1'b1;
                            n_out = r_hb;
                        end
                        n_hold = 1'b1;
                        n_hb = '{kind: KIND_BYTE, data: {24'd0, i_byte}, last: 1'b0};
                        o_cmd.renorm = 1'b1;
                        n_n = r_n + 2'd1;
                    end
                end else if (!r_hold || space) begin
                    if (r_hold) begin
                        n_ov = 1'b1;
                        n_out = r_hb;
                        n_out.last = 1'b1;
                    end
                    n_hold = 1'b0;
                    n_state = S_RECIP;
                end
            end
            S_RECIP: if (i_recip_done) n_state = S_MUL;
            S_MUL: begin
                o_cmd.mul1 = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_hold  <= 1'b0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_hold  <= n_hold;
            r_n     <= n_n;
        end
        r_out <= n_out;
        r_hb  <= n_hb;
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready) else $error("ready while busy");
    a_renorm_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.renorm |-> (r_n != 2'd2)) else $error("too many bytes");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_out_ready) |=> (r_ov && $stable(r_out))) else $error("output lost");
endmodule

>>> rtl/rans_byte_encoder_unit.sv
// Top level: rANS byte encoder with byte renormalisation
//  channel | dir | payload
//  in_ch   | in  | operation, context_req, symbol, cum_freq, freq
//  out_ch  | out | kind, data, last
//  cfg_ch  | in  | log_range
// Load and flush return to idle from decode; encode runs the bit-serial
// reciprocal divider (48 steps) started at decode, then product and update;
// up to two renormalisation bytes overlap the divider.
// Reset is synchronous; the table is undefined until loaded.
// Output stalls hold the controller before the next transaction is emitted.
module rans_byte_encoder_unit import rbe_pkg::*; #(
    parameter int unsigned CONTEXTS  = CONTEXTS_DEF,
    parameter int unsigned FLOOR_LOG = FLOOR_LOG_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    rbe_if.sink   in_ch,
    rbe_if.source out_ch,
    rbe_if.sink   cfg_ch
);
    logic [LR_W-1:0] r_lr;
    t_cmd    cmd;
    t_status status;
    logic    recip_go, recip_done;
    logic [31:0] state32;
    logic [7:0]  byte_v;

    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_lr <= LR_RESET;
        else if (cfg_ch.valid) r_lr <= cfg_ch.payload;
    end

    rbe_datapath #(.CONTEXTS(CONTEXTS), .FLOOR_LOG(FLOOR_LOG)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_item       (in_ch.payload),
        .i_log_range  (r_lr),
        .i_recip_go   (recip_go),
        .o_recip_done (recip_done),
        .o_status     (status),
        .o_state32    (state32),
        .o_byte       (byte_v)
    );

    rbe_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .o_in_ready   (in_ch.ready),
        .i_status     (status),
        .i_recip_done (recip_done),
        .o_recip_go   (recip_go),
        .o_cmd        (cmd),
        .i_state32    (state32),
        .i_byte       (byte_v),
        .o_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .o_out        (out_ch.payload)
    );
endmodule
